### hw/rtl/scd_pkg.sv
// ============================================================================
// Sketch command decoder package
// Shared types, codes and defaults for the sketch command decoder.
// ============================================================================
package scd_pkg;

    // Defaults for the top-level parameters.
    localparam int COORD_WIDTH_DEF = 16;
    localparam int CMD_DEPTH_DEF   = 2;
    localparam int RES_DEPTH_DEF   = 2;

    // Opcodes in bits 7:6 of a command byte.
    localparam logic [1:0] OP_DX   = 2'd0;
    localparam logic [1:0] OP_DY   = 2'd1;
    localparam logic [1:0] OP_TOOL = 2'd2;
    localparam logic [1:0] OP_DATA = 2'd3;

    // Tool codes.
    localparam logic [1:0] TL_NONE  = 2'd0;
    localparam logic [1:0] TL_LINE  = 2'd1;
    localparam logic [1:0] TL_BLOCK = 2'd2;

    // TOOL operand codes.
    localparam logic [5:0] TC_NONE      = 6'd0;
    localparam logic [5:0] TC_LINE      = 6'd1;
    localparam logic [5:0] TC_BLOCK     = 6'd2;
    localparam logic [5:0] TC_COLOUR    = 6'd3;
    localparam logic [5:0] TC_TARGETX   = 6'd4;
    localparam logic [5:0] TC_TARGETY   = 6'd5;
    localparam logic [5:0] TC_SHOW      = 6'd6;
    localparam logic [5:0] TC_PAUSE     = 6'd7;
    localparam logic [5:0] TC_NEXTFRAME = 6'd8;

    // Event codes on the result side.
    localparam logic [2:0] EV_LINE   = 3'd0;
    localparam logic [2:0] EV_BLOCK  = 3'd1;
    localparam logic [2:0] EV_COLOUR = 3'd2;
    localparam logic [2:0] EV_SHOW   = 3'd3;
    localparam logic [2:0] EV_PAUSE  = 3'd4;
    localparam logic [2:0] EV_FRAME  = 3'd5;

    // Decoded command kinds handed from the front end to the back end.
    localparam logic [3:0] K_NOP      = 4'd0;
    localparam logic [3:0] K_DX       = 4'd1;
    localparam logic [3:0] K_DY       = 4'd2;
    localparam logic [3:0] K_DATA     = 4'd3;
    localparam logic [3:0] K_TOOL_SEL = 4'd4;
    localparam logic [3:0] K_COLOUR   = 4'd5;
    localparam logic [3:0] K_TARGETX  = 4'd6;
    localparam logic [3:0] K_TARGETY  = 4'd7;
    localparam logic [3:0] K_SHOW     = 4'd8;
    localparam logic [3:0] K_PAUSE    = 4'd9;
    localparam logic [3:0] K_FRAME    = 4'd10;

    typedef struct packed {
        logic [3:0] kind;
        logic [5:0] opnd;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic [31:0] value;
    } res_t;

endpackage

### hw/rtl/sketch_command_decoder_core.sv
// ============================================================================
// Sketch command decoder core
// Decodes vector drawing command bytes into line, block, colour, show,
// pause and frame-end events.
// ============================================================================
//
// Channel   Handshake           Words
// --------  ------------------  ------------------------------------------
// command   push / full         cmd_byte, end_of_sketch
// event     pop / empty         event_res, pos_x, pos_y, arg_a, arg_b, value
//
// One command word is taken every cycle while full is low. The front end
// classifies the byte in the cycle it is accepted and writes the decoded
// command into a short queue; the back end executes one queued command per
// cycle. A command is registered in the command queue, and its event in the
// event queue, before the event shows on the event ports. The back end only
// stalls when the event queue is full, and the command queue absorbs that
// stall before full rises. Reset clears the queues, the positions, the
// targets and the accumulator, and selects the line tool.
//
// Bytes that cause no event (DX, DATA, tool selects, target loads) still pass
// through the back end to update the drawing state; unknown tool codes are
// dropped in the front end. Coordinates are COORD_WIDTH bits wide and wrap;
// they are reported as their low 16 bits.
//
module sketch_command_decoder_core #(
    parameter int COORD_WIDTH = scd_pkg::COORD_WIDTH_DEF,
    parameter int CMD_DEPTH   = scd_pkg::CMD_DEPTH_DEF,
    parameter int RES_DEPTH   = scd_pkg::RES_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // Command side
    input  logic               push,
    output logic               full,
    input  logic [7:0]         cmd_byte,
    input  logic               end_of_sketch,
    // Event side
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         event_res,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] arg_a,
    output logic signed [15:0] arg_b,
    output logic [31:0]        value
);

    localparam int CMDW = $bits(scd_pkg::cmd_t);

    scd_pkg::cmd_t front_cmd;
    scd_pkg::cmd_t back_cmd;
    logic [CMDW-1:0] back_cmd_raw;
    logic          q_push;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    scd_pkg::res_t res;

    // Front end: accept and classify each command byte.
    scd_front u_front (
        .push          (push),
        .full          (full),
        .cmd_byte      (cmd_byte),
        .end_of_sketch (end_of_sketch),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (front_cmd)
    );

    // Decoded command queue between the two halves.
    scd_fifo #(
        .WIDTH (CMDW),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (front_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (back_cmd_raw),
        .empty   (q_empty)
    );

    assign back_cmd = scd_pkg::cmd_t'(back_cmd_raw);

    // Back end: drawing state, event generation and the event queue.
    scd_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .RES_DEPTH   (RES_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .res       (res),
        .res_empty (empty),
        .res_pop   (pop)
    );

    assign event_res = res.event_res;
    assign pos_x     = $signed(res.pos_x);
    assign pos_y     = $signed(res.pos_y);
    assign arg_a     = $signed(res.arg_a);
    assign arg_b     = $signed(res.arg_b);
    assign value     = res.value;

endmodule

### hw/rtl/scd_fifo.sv
// ============================================================================
// Sketch command decoder word queue
// Small register queue; the head word is shown while empty is low.
// ============================================================================
module scd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/scd_front.sv
// ============================================================================
// Sketch command decoder front end
// Accepts command bytes and classifies them into decoded commands.
// ============================================================================
module scd_front (
    input  logic          push,
    output logic          full,
    input  logic [7:0]    cmd_byte,
    input  logic          end_of_sketch,
    input  logic          q_full,
    output logic          q_push,
    output scd_pkg::cmd_t q_data
);

    logic [1:0] opc;
    logic [5:0] raw;
    logic       tool_known;
    logic [3:0] kind;

    assign opc = cmd_byte[7:6];
    assign raw = cmd_byte[5:0];

    // Tool codes run from zero to eight; anything else is dropped here.
    assign tool_known = (raw[5:4] == 2'b00) && (!raw[3] || (raw[2:0] == 3'b000));

    always_comb
    begin
        kind = scd_pkg::K_NOP;
        if (end_of_sketch)
        begin
            kind = scd_pkg::K_FRAME;
        end
        else
        begin
            unique case (opc)
                scd_pkg::OP_DX:   kind = scd_pkg::K_DX;
                scd_pkg::OP_DY:   kind = scd_pkg::K_DY;
                scd_pkg::OP_DATA: kind = scd_pkg::K_DATA;
                scd_pkg::OP_TOOL:
                begin
                    if (tool_known)
                    begin
                        unique case (raw)
                            scd_pkg::TC_NONE,
                            scd_pkg::TC_LINE,
                            scd_pkg::TC_BLOCK:     kind = scd_pkg::K_TOOL_SEL;
                            scd_pkg::TC_COLOUR:    kind = scd_pkg::K_COLOUR;
                            scd_pkg::TC_TARGETX:   kind = scd_pkg::K_TARGETX;
                            scd_pkg::TC_TARGETY:   kind = scd_pkg::K_TARGETY;
                            scd_pkg::TC_SHOW:      kind = scd_pkg::K_SHOW;
                            scd_pkg::TC_PAUSE:     kind = scd_pkg::K_PAUSE;
                            scd_pkg::TC_NEXTFRAME: kind = scd_pkg::K_FRAME;
                            default:               kind = scd_pkg::K_NOP;
                        endcase
                    end
                end
                default: kind = scd_pkg::K_NOP;
            endcase
        end
    end

    assign full        = q_full;
    assign q_push      = push && !q_full && (kind != scd_pkg::K_NOP);
    assign q_data.kind = kind;
    assign q_data.opnd = raw;

endmodule

### hw/rtl/scd_back.sv
// ============================================================================
// Sketch command decoder back end
// Executes decoded commands against the drawing state and queues events.
// ============================================================================
module scd_back #(
    parameter int COORD_WIDTH = scd_pkg::COORD_WIDTH_DEF,
    parameter int RES_DEPTH   = scd_pkg::RES_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  scd_pkg::cmd_t cmd,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    output scd_pkg::res_t res,
    output logic          res_empty,
    input  logic          res_pop
);

    localparam int CW = COORD_WIDTH;
    localparam int RW = $bits(scd_pkg::res_t);

    logic [CW-1:0] cur_x_reg, cur_x_next;
    logic [CW-1:0] cur_y_reg, cur_y_next;
    logic [CW-1:0] tgt_x_reg, tgt_x_next;
    logic [CW-1:0] tgt_y_reg, tgt_y_next;
    logic [31:0]   acc_reg, acc_next;
    logic [1:0]    tool_reg, tool_next;

    logic [CW-1:0] opnd_ext;
    logic [CW-1:0] dy_tgt;
    logic [CW-1:0] blk_w;
    logic [CW-1:0] blk_h;
    logic          res_full;
    logic          res_push;
    logic          emit;
    scd_pkg::res_t res_word;
    logic [RW-1:0] res_raw;

    // Coordinates are reported as their low 16 bits, zero filled when narrower.
    function automatic logic [15:0] to16(input logic [CW-1:0] v);
        logic [CW+15:0] ext;
        begin
            ext  = {16'b0, v};
            to16 = ext[15:0];
        end
    endfunction

    assign opnd_ext = {{(CW - 6){cmd.opnd[5]}}, cmd.opnd};
    assign dy_tgt   = tgt_y_reg + opnd_ext;
    assign blk_w    = tgt_x_reg - cur_x_reg;
    assign blk_h    = dy_tgt - cur_y_reg;
    assign cmd_pop  = !cmd_empty && !res_full;

    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        tgt_x_next = tgt_x_reg;
        tgt_y_next = tgt_y_reg;
        acc_next   = acc_reg;
        tool_next  = tool_reg;
        emit       = 1'b0;
        res_word   = '0;
        unique case (cmd.kind)
            scd_pkg::K_DX:
            begin
                tgt_x_next = tgt_x_reg + opnd_ext;
            end
            scd_pkg::K_DY:
            begin
                tgt_y_next = dy_tgt;
                cur_x_next = tgt_x_reg;
                cur_y_next = dy_tgt;
                res_word.pos_x = to16(cur_x_reg);
                res_word.pos_y = to16(cur_y_reg);
                if (tool_reg == scd_pkg::TL_LINE)
                begin
                    emit               = 1'b1;
                    res_word.event_res = scd_pkg::EV_LINE;
                    res_word.arg_a     = to16(tgt_x_reg);
                    res_word.arg_b     = to16(dy_tgt);
                end
                else if (tool_reg == scd_pkg::TL_BLOCK)
                begin
                    emit               = 1'b1;
                    res_word.event_res = scd_pkg::EV_BLOCK;
                    res_word.arg_a     = to16(blk_w);
                    res_word.arg_b     = to16(blk_h);
                end
            end
            scd_pkg::K_DATA:
            begin
                acc_next = {acc_reg[25:0], cmd.opnd};
            end
            scd_pkg::K_TOOL_SEL:
            begin
                tool_next = cmd.opnd[1:0];
                acc_next  = '0;
            end
            scd_pkg::K_COLOUR:
            begin
                emit               = 1'b1;
                res_word.event_res = scd_pkg::EV_COLOUR;
                res_word.value     = acc_reg;
                acc_next           = '0;
            end
            scd_pkg::K_TARGETX:
            begin
                tgt_x_next = acc_reg[CW-1:0];
                acc_next   = '0;
            end
            scd_pkg::K_TARGETY:
            begin
                tgt_y_next = acc_reg[CW-1:0];
                acc_next   = '0;
            end
            scd_pkg::K_SHOW:
            begin
                emit               = 1'b1;
                res_word.event_res = scd_pkg::EV_SHOW;
                acc_next           = '0;
            end
            scd_pkg::K_PAUSE:
            begin
                emit               = 1'b1;
                res_word.event_res = scd_pkg::EV_PAUSE;
                res_word.value     = acc_reg;
                acc_next           = '0;
            end
            scd_pkg::K_FRAME:
            begin
                emit               = 1'b1;
                res_word.event_res = scd_pkg::EV_FRAME;
                cur_x_next         = '0;
                cur_y_next         = '0;
                tgt_x_next         = '0;
                tgt_y_next         = '0;
                acc_next           = '0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            tgt_x_reg <= '0;
            tgt_y_reg <= '0;
            acc_reg   <= '0;
            tool_reg  <= scd_pkg::TL_LINE;
        end
        else if (cmd_pop)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            tgt_x_reg <= tgt_x_next;
            tgt_y_reg <= tgt_y_next;
            acc_reg   <= acc_next;
            tool_reg  <= tool_next;
        end
    end

    assign res_push = cmd_pop && emit;

    scd_fifo #(
        .WIDTH (RW),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_word),
        .full    (res_full),
        .pop     (res_pop),
        .rd_data (res_raw),
        .empty   (res_empty)
    );

    assign res = scd_pkg::res_t'(res_raw);

endmodule

### test/sketch_command_decoder_core_tb.sv
// ============================================================================
// Sketch command decoder core testbench
// Streams directed and random command words into the decoder through its
// push/full queue and checks every event word popped from the result queue
// against a behavioral drawing-state model in the bench or a typed script event.
// ============================================================================
`timescale 1ns / 100ps

module sketch_command_decoder_core_tb;

    // The model keeps coordinates at the same width as the block instance.
    localparam int COORD_W      = 16;
    // Random command words after the directed script.
    localparam int RANDOM_WORDS = 1400;
    // Cycles in a row with no word moving on either side before giving up.
    // The slowest correct exchange is the longest random gap on each side plus
    // the pass through both queues, so this is many times the worst case.
    localparam int STALL_LIMIT  = 1000;
    // Extra cycles after the last expected event, to catch stray words.
    localparam int DRAIN_CYCLES = 16;
    // Number of words after which each side redraws whether it idles.
    localparam int BURST_SPAN   = 128;

    // One row of the directed script. Where the expected event is obvious
    // it is typed into the row; otherwise the model decides it.
    typedef struct {
        logic [7:0]    cmd;
        logic          eos;
        bit            typed;
        scd_pkg::res_t ev;
    } script_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [7:0]         cmd_byte;
    logic               end_of_sketch;
    logic               empty;
    logic               pop;
    logic [2:0]         event_res;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] arg_a;
    logic signed [15:0] arg_b;
    logic [31:0]        value;

    // Drawing state of the model: pen position, aim point (the target),
    // data accumulator and the selected tool.
    logic [COORD_W-1:0] pen_x;
    logic [COORD_W-1:0] pen_y;
    logic [COORD_W-1:0] aim_x;
    logic [COORD_W-1:0] aim_y;
    logic [31:0]        data_acc;
    logic [1:0]         pen_tool;

    // Events that the accepted command words have caused and that have not
    // been popped yet, oldest first.
    scd_pkg::res_t pending_events[$];
    script_row_t   script[$];

    int  mismatches   = 0;
    int  stall_cycles = 0;
    bit  tx_steady    = 1'b0;
    bit  rx_steady    = 1'b0;

    sketch_command_decoder_core #(
        .COORD_WIDTH(COORD_W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd_byte     (cmd_byte),
        .end_of_sketch(end_of_sketch),
        .empty        (empty),
        .pop          (pop),
        .event_res    (event_res),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .arg_a        (arg_a),
        .arg_b        (arg_b),
        .value        (value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command word to the drawing state and returns 1 when the
    // word causes an event, which is then left in ev.
    function automatic bit decode_command(input logic [7:0] cmd, input logic eos,
                                          output scd_pkg::res_t ev);
        logic [1:0]         opc;
        logic [5:0]         raw;
        logic [COORD_W-1:0] delta;
        logic [31:0]        acc_old;
        bit                 hit;
        bit                 frame_end;

        opc       = cmd[7:6];
        raw       = cmd[5:0];
        delta     = {{(COORD_W - 6){raw[5]}}, raw};
        ev        = '0;
        hit       = 1'b0;
        frame_end = eos;
        if (!eos)
        begin
            case (opc)
                scd_pkg::OP_DX:
                begin
                    aim_x = aim_x + delta;
                end
                scd_pkg::OP_DATA:
                begin
                    // The top six bits fall out of the accumulator.
                    data_acc = {data_acc[25:0], raw};
                end
                scd_pkg::OP_DY:
                begin
                    aim_y = aim_y + delta;
                    if (pen_tool == scd_pkg::TL_LINE)
                    begin
                        ev.event_res = scd_pkg::EV_LINE;
                        ev.pos_x     = pen_x[15:0];
                        ev.pos_y     = pen_y[15:0];
                        ev.arg_a     = aim_x[15:0];
                        ev.arg_b     = aim_y[15:0];
                        hit          = 1'b1;
                    end
                    else if (pen_tool == scd_pkg::TL_BLOCK)
                    begin
                        ev.event_res = scd_pkg::EV_BLOCK;
                        ev.pos_x     = pen_x[15:0];
                        ev.pos_y     = pen_y[15:0];
                        ev.arg_a     = aim_x[15:0] - pen_x[15:0];
                        ev.arg_b     = aim_y[15:0] - pen_y[15:0];
                        hit          = 1'b1;
                    end
                    // With no tool the pen still moves, silently.
                    pen_x = aim_x;
                    pen_y = aim_y;
                end
                default:
                begin
                    // Negative tool codes and codes past next frame do
                    // nothing at all, not even clear the accumulator.
                    if (!raw[5] && raw <= scd_pkg::TC_NEXTFRAME)
                    begin
                        acc_old  = data_acc;
                        data_acc = '0;
                        case (raw)
                            scd_pkg::TC_NONE:    pen_tool = scd_pkg::TL_NONE;
                            scd_pkg::TC_LINE:    pen_tool = scd_pkg::TL_LINE;
                            scd_pkg::TC_BLOCK:   pen_tool = scd_pkg::TL_BLOCK;
                            scd_pkg::TC_TARGETX: aim_x = acc_old[COORD_W-1:0];
                            scd_pkg::TC_TARGETY: aim_y = acc_old[COORD_W-1:0];
                            scd_pkg::TC_COLOUR:
                            begin
                                ev.event_res = scd_pkg::EV_COLOUR;
                                ev.value     = acc_old;
                                hit          = 1'b1;
                            end
                            scd_pkg::TC_SHOW:
                            begin
                                ev.event_res = scd_pkg::EV_SHOW;
                                hit          = 1'b1;
                            end
                            scd_pkg::TC_PAUSE:
                            begin
                                ev.event_res = scd_pkg::EV_PAUSE;
                                ev.value     = acc_old;
                                hit          = 1'b1;
                            end
                            default:
                            begin
                                frame_end = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
        // A frame end, from next frame or from the end of the sketch, wipes
        // the position, the aim point and the accumulator but keeps the tool.
        if (frame_end)
        begin
            pen_x        = '0;
            pen_y        = '0;
            aim_x        = '0;
            aim_y        = '0;
            data_acc     = '0;
            ev           = '0;
            ev.event_res = scd_pkg::EV_FRAME;
            hit          = 1'b1;
        end
        return hit;
    endfunction

    function automatic script_row_t script_row(
        input logic [7:0]  cmd,
        input logic        eos = 1'b0,
        input bit          typed = 1'b0,
        input logic [2:0]  ev_code = scd_pkg::EV_LINE,
        input logic [15:0] a = '0,
        input logic [15:0] b = '0,
        input logic [31:0] val = '0);
        script_row_t row;

        row.cmd          = cmd;
        row.eos          = eos;
        row.typed        = typed;
        row.ev           = '0;
        row.ev.event_res = ev_code;
        row.ev.arg_a     = a;
        row.ev.arg_b     = b;
        row.ev.value     = val;
        return row;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: %s", $time, what);
    endtask

    // Offers one command word after a random gap, waits until the block takes
    // it, and then runs the model on it. The expected event of a typed row
    // replaces the one the model works out.
    task automatic send_word(input logic [7:0] cmd, input logic eos,
                             input bit typed = 1'b0,
                             input scd_pkg::res_t typed_ev = '0);
        int            gap;
        scd_pkg::res_t ev;

        gap = tx_steady ? 0 : int'($urandom_range(0, 7));
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push          <= 1'b1;
        cmd_byte      <= cmd;
        end_of_sketch <= eos;
        do
            @(posedge clk);
        while (full !== 1'b0);
        if (decode_command(cmd, eos, ev))
        begin
            pending_events.push_back(typed ? typed_ev : ev);
        end
    endtask

    // Watchdog: a hung block or a lost event stops the run here.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Event side: pops with a random stall before each word and compares
    // every popped word with the oldest pending event. Outputs are read in
    // the same step as the edge, so they hold the values the block showed
    // when the word was taken.
    initial
    begin : event_checker
        int            gap;
        int            popped;
        scd_pkg::res_t want;

        pop    = 1'b0;
        popped = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (popped % BURST_SPAN == 0)
            begin
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            gap = rx_steady ? 0 : int'($urandom_range(0, 7));
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty !== 1'b0);
            popped++;
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("event %0d popped with nothing pending",
                                          event_res));
            end
            else
            begin
                want = pending_events.pop_front();
                if (event_res !== want.event_res)
                    report_mismatch($sformatf("event_res got %0d want %0d",
                                              event_res, want.event_res));
                if (pos_x !== want.pos_x)
                    report_mismatch($sformatf("pos_x got %h want %h", pos_x, want.pos_x));
                if (pos_y !== want.pos_y)
                    report_mismatch($sformatf("pos_y got %h want %h", pos_y, want.pos_y));
                if (arg_a !== want.arg_a)
                    report_mismatch($sformatf("arg_a got %h want %h", arg_a, want.arg_a));
                if (arg_b !== want.arg_b)
                    report_mismatch($sformatf("arg_b got %h want %h", arg_b, want.arg_b));
                if (value !== want.value)
                    report_mismatch($sformatf("value got %h want %h", value, want.value));
            end
        end
    end

    // Command side and run control.
    initial
    begin : command_source
        int         sel;
        logic [7:0] cmd;
        logic [5:0] code;
        logic       eos;

        rst_n         = 1'b0;
        push          = 1'b0;
        cmd_byte      = '0;
        end_of_sketch = 1'b0;
        pen_x         = '0;
        pen_y         = '0;
        aim_x         = '0;
        aim_y         = '0;
        data_acc      = '0;
        pen_tool      = scd_pkg::TL_LINE;

        // Directed script. The line tool is active out of reset.
        script.push_back(script_row({scd_pkg::OP_DY, 6'h00}, 1'b0, 1'b1,
                                    scd_pkg::EV_LINE, 16'h0000, 16'h0000));
        // Largest positive and most negative operands.
        script.push_back(script_row({scd_pkg::OP_DX, 6'h1F}));
        script.push_back(script_row({scd_pkg::OP_DY, 6'h20}, 1'b0, 1'b1,
                                    scd_pkg::EV_LINE, 16'h001F, 16'hFFE0));
        // Six full data words overflow the accumulator to all ones.
        repeat (6) script.push_back(script_row({scd_pkg::OP_DATA, 6'h3F}));
        script.push_back(script_row({scd_pkg::OP_TOOL, scd_pkg::TC_COLOUR}, 1'b0, 1'b1,
                                    scd_pkg::EV_COLOUR, 16'h0, 16'h0, 32'hFFFF_FFFF));
        script.push_back(script_row({scd_pkg::OP_TOOL, scd_pkg::TC_SHOW}, 1'b0, 1'b1,
                                    scd_pkg::EV_SHOW));
        script.push_back(script_row({scd_pkg::OP_TOOL, scd_pkg::TC_PAUSE}, 1'b0, 1'b1,
                                    scd_pkg::EV_PAUSE));
        // Block drawn from the current pen position.
        script.push_back(script_row({scd_pkg::OP_TOOL, scd_pkg::TC_BLOCK}));
        script.push_back(script_row({scd_pkg::OP_DX, 6'h3F}));
        script.push_back(script_row({scd_pkg::OP_DY, 6'h05}));
        // Aim point loaded from the accumulator.
        script.push_back(script_row({scd_pkg::OP_DATA, 6'h2A}));
        script.push_back(script_row({scd_pkg::OP_TOOL, scd_pkg::TC_TARGETX}));
        script.push_back(script_row({scd_pkg::OP_DATA, 6'h11}));
        script.push_back(script_row({scd_pkg::OP_TOOL, scd_pkg::TC_TARGETY}));
        // Unknown tool codes leave the accumulator alone.
        script.push_back(script_row({scd_pkg::OP_DATA, 6'h07}));
        script.push_back(script_row({scd_pkg::OP_TOOL, 6'h3F}));
        script.push_back(script_row({scd_pkg::OP_TOOL, 6'h09}));
        script.push_back(script_row({scd_pkg::OP_TOOL, scd_pkg::TC_PAUSE}, 1'b0, 1'b1,
                                    scd_pkg::EV_PAUSE, 16'h0, 16'h0, 32'h0000_0007));
        // With no tool a DY moves the pen but draws nothing.
        script.push_back(script_row({scd_pkg::OP_TOOL, scd_pkg::TC_NONE}));
        script.push_back(script_row({scd_pkg::OP_DY, 6'h01}));
        // Both ways of ending a frame; the byte is ignored at sketch end.
        script.push_back(script_row({scd_pkg::OP_TOOL, scd_pkg::TC_NEXTFRAME}, 1'b0,
                                    1'b1, scd_pkg::EV_FRAME));
        script.push_back(script_row(8'hFF, 1'b1, 1'b1, scd_pkg::EV_FRAME));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (i % BURST_SPAN == 0)
                tx_steady = ($urandom_range(0, 3) == 0);
            send_word(script[i].cmd, script[i].eos, script[i].typed, script[i].ev);
        end

        // Random part: mostly well-formed commands with random operands, the
        // tool codes kept to the known ones, plus a little raw noise that
        // also reaches the unknown tool codes.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % BURST_SPAN == 0)
                tx_steady = ($urandom_range(0, 3) == 0);
            sel  = int'($urandom_range(0, 99));
            cmd  = 8'($urandom_range(0, 255));
            code = 6'($urandom_range(0, 8));
            eos  = 1'b0;
            if (sel < 2)
                eos = 1'b1;
            else if (sel < 27)
                cmd[7:6] = scd_pkg::OP_DX;
            else if (sel < 52)
                cmd[7:6] = scd_pkg::OP_DY;
            else if (sel < 72)
                cmd[7:6] = scd_pkg::OP_DATA;
            else if (sel < 94)
                cmd = {scd_pkg::OP_TOOL, code};
            send_word(cmd, eos);
        end
        push <= 1'b0;

        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
